@@ rtl/sap_pkg.sv @@
// Shared types and constants of the stepper angle pointer.
// Used by the controller, the datapath, the top level and the checker.
package sap_pkg;

  localparam int unsigned FULL_TURN_Q6 = 23040;
  localparam int unsigned ANGLE_W      = 16;
  localparam int unsigned NORM_W       = 15;
  localparam int unsigned PROD_W       = 31;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned OUT_POS_W    = 32;
  localparam int unsigned OUT_TDATA_W  = 40;
  localparam int unsigned IN_TDATA_W   = 16;
  localparam int unsigned APB_ADDR_W   = 4;
  localparam int unsigned APB_DATA_W   = 32;

  // One turn is 45 * 2^9. The power of two is shifted off and the division by 45
  // is a multiplication by ceil(2^28 / 45), exact for every 22-bit input.
  localparam int unsigned TURN_POW2_SH = 9;
  localparam int unsigned QUO_IN_W     = PROD_W - TURN_POW2_SH;
  localparam int unsigned RECIP_W      = 23;
  localparam int unsigned RECIP_SH     = 28;
  localparam int unsigned RECIP_PROD_W = QUO_IN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_45 = 23'd5965233;

  localparam logic [1:0] REG_STEPS_PER_REV = 2'd0;
  localparam logic [1:0] REG_STEP_INTERVAL = 2'd1;
  localparam logic [1:0] REG_MOTOR_ENABLE  = 2'd2;

  localparam logic [CFG_W-1:0] STEPS_PER_REV_RST = 16'd200;
  localparam logic [CFG_W-1:0] STEP_INTERVAL_RST = 16'd1200;
  localparam logic             MOTOR_ENABLE_RST  = 1'b1;

  localparam logic OP_TICK       = 1'b0;
  localparam logic OP_SET_TARGET = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] steps_per_rev;
    logic [CFG_W-1:0] step_interval_us;
    logic             motor_enable;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic tick;
    logic norm;
    logic mul;
    logic div_start;
    logic take_tgt;
    logic fix;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } status_t;

  typedef struct packed {
    logic                 step_pulse;
    logic                 direction;
    logic [OUT_POS_W-1:0] position;
    logic                 at_target;
  } res_t;

endpackage

@@ rtl/sap_divider.sv @@
// Restoring divider that keeps only the remainder, one dividend bit per cycle.
// Depends on nothing; instantiated by sap_datapath.
module sap_divider #(
  parameter int unsigned DVD_W = 32,
  parameter int unsigned DVS_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVS_W-1:0] remainder_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o      = busy_q;
  assign remainder_o = rem_q;

endmodule

@@ rtl/sap_datapath.sv @@
// Datapath of the stepper angle pointer: position state, angle scaling and path choice.
// Depends on sap_pkg and sap_divider.
module sap_datapath
  import sap_pkg::*;
#(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  cfg_t                cfg_i,
  input  logic [ANGLE_W-1:0]  angle_i,
  output status_t             status_o,
  output res_t                res_o
);

  logic signed [ANGLE_W-1:0] angle_q;
  logic [NORM_W-1:0]         norm_q, norm_d;
  logic [PROD_W-1:0]         prod_q;
  logic [CFG_W-1:0]          tgt_q;
  logic [POS_WIDTH-1:0]      current_q, current_d;
  logic [POS_WIDTH-1:0]      target_q, target_d;
  logic [CFG_W-1:0]          elapsed_q, elapsed_d;
  logic                      dir_q, dir_d;
  logic                      pulse_q, pulse_d;

  logic [CFG_W-1:0]          spr_eff;
  logic [POS_WIDTH-1:0]      cur_mag;
  logic                      cur_neg;
  logic                      div_busy;
  logic [CFG_W-1:0]          div_rem;
  logic [QUO_IN_W-1:0]       prod_hi;
  logic [RECIP_PROD_W-1:0]   recip_prod;

  logic signed [ANGLE_W:0]   a17, t17;
  localparam logic signed [ANGLE_W:0] FULL_S = $signed(17'(FULL_TURN_Q6));

  logic [CFG_W-1:0]          cm;
  logic signed [CFG_W+1:0]   diff, diff_adj, half;
  logic signed [63:0]        diff64;
  logic signed [63:0]        cur64;
  logic [CFG_W-1:0]          elapsed_inc;

  assign spr_eff = (cfg_i.steps_per_rev == '0) ? CFG_W'(1) : cfg_i.steps_per_rev;
  assign cur_neg = current_q[POS_WIDTH-1];
  assign cur_mag = cur_neg ? (POS_WIDTH'(0) - current_q) : current_q;

  // The serial unit reduces the magnitude of the current position modulo one revolution.
  sap_divider #(
    .DVD_W(POS_WIDTH),
    .DVS_W(CFG_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cur_mag),
    .divisor_i  (spr_eff),
    .busy_o     (div_busy),
    .remainder_o(div_rem)
  );

  // Step index: the scaled angle over one turn, taken as a shift and a reciprocal multiply.
  assign prod_hi    = prod_q[PROD_W-1:TURN_POW2_SH];
  assign recip_prod = RECIP_PROD_W'(prod_hi) * RECIP_PROD_W'(RECIP_45);

  // Wrap the angle into one turn; at most two corrections cover the 16-bit range.
  always_comb begin
    a17 = {angle_q[ANGLE_W-1], angle_q};
    t17 = a17;
    if (a17 < 0) begin
      t17 = a17 + FULL_S;
      if (t17 < 0) begin
        t17 = t17 + FULL_S;
      end
    end else if (a17 >= FULL_S) begin
      t17 = a17 - FULL_S;
    end
    norm_d = t17[NORM_W-1:0];
  end

  // Shortest path: bring the difference into the window of half a turn.
  always_comb begin
    cm = (cur_neg && (div_rem != '0)) ? (spr_eff - div_rem) : div_rem;
    diff = $signed({2'b00, tgt_q}) - $signed({2'b00, cm});
    half = $signed({3'b000, spr_eff[CFG_W-1:1]});
    diff_adj = diff;
    if (diff > half) begin
      diff_adj = diff - $signed({2'b00, spr_eff});
    end else if (diff < -half) begin
      diff_adj = diff + $signed({2'b00, spr_eff});
    end
    diff64 = 64'(diff_adj);
  end

  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : (elapsed_q + 1'b1);

  always_comb begin
    current_d = current_q;
    target_d  = target_q;
    elapsed_d = elapsed_q;
    dir_d     = dir_q;
    pulse_d   = pulse_q;
    if (cmd_i.capture) begin
      pulse_d = 1'b0;
    end
    if (cmd_i.tick) begin
      elapsed_d = elapsed_inc;
      if ((current_q != target_q) && (elapsed_inc >= cfg_i.step_interval_us)) begin
        elapsed_d = '0;
        pulse_d   = 1'b1;
        if ($signed(target_q) > $signed(current_q)) begin
          dir_d     = 1'b1;
          current_d = current_q + 1'b1;
        end else begin
          dir_d     = 1'b0;
          current_d = current_q - 1'b1;
        end
      end
    end
    if (cmd_i.fix) begin
      target_d = current_q + diff64[POS_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_q <= '0;
      target_q  <= '0;
      elapsed_q <= '0;
      dir_q     <= 1'b0;
      pulse_q   <= 1'b0;
    end else begin
      current_q <= current_d;
      target_q  <= target_d;
      elapsed_q <= elapsed_d;
      dir_q     <= dir_d;
      pulse_q   <= pulse_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      angle_q <= $signed(angle_i);
    end
    if (cmd_i.norm) begin
      norm_q <= norm_d;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(norm_q) * PROD_W'(spr_eff);
    end
    if (cmd_i.take_tgt) begin
      tgt_q <= recip_prod[RECIP_SH +: CFG_W];
    end
  end

  assign cur64 = 64'($signed(current_q));

  assign status_o.div_busy = div_busy;
  assign res_o.step_pulse  = pulse_q;
  assign res_o.direction   = dir_q;
  assign res_o.position    = cur64[OUT_POS_W-1:0];
  assign res_o.at_target   = (current_q == target_q);

endmodule

@@ rtl/sap_ctrl.sv @@
// Controller state machine of the stepper angle pointer.
// Depends on sap_pkg; drives sap_datapath through cmd_t.
module sap_ctrl
  import sap_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_op_i,
  output logic    in_ready_o,
  input  logic    out_free_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TICK  = 4'd1;
  localparam logic [3:0] S_NORM  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_SCALE = 4'd4;
  localparam logic [3:0] S_DIVM  = 4'd5;
  localparam logic [3:0] S_WAITM = 4'd6;
  localparam logic [3:0] S_FIX   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = (in_op_i == OP_SET_TARGET) ? S_NORM : S_TICK;
        end
      end
      S_TICK: begin
        cmd_o.tick = 1'b1;
        state_d    = S_EMIT;
      end
      S_NORM: begin
        cmd_o.norm = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.take_tgt = 1'b1;
        state_d        = S_DIVM;
      end
      S_DIVM: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_WAITM;
      end
      S_WAITM: begin
        if (!status_i.div_busy) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/stepper_angle_pointer.sv @@
// Top level of the stepper angle pointer: configuration registers, stream ports, result register.
// Depends on sap_pkg, sap_ctrl and sap_datapath.
//
// Usage. Items enter on the slave stream: s_axis_tuser carries the operation
// (0 is a one microsecond time tick, 1 sets a new target angle) and
// s_axis_tdata carries the signed angle in 1/64 degree. Every item produces
// exactly one result item on the master stream, in order.
// A time tick goes from the idle state to the tick state, then to the emit
// state, which loads its result into the output register once that is free.
// A set-target item goes through the NORM, MUL and SCALE states, which wrap
// the angle into one turn and scale it to a step index. The DIVM state then
// starts the serial remainder unit, which takes one bit of the current
// position per cycle to reduce it modulo the steps per revolution; the FIX
// state sets the new target and the EMIT state loads the result.
// At most one item is in work at a time; the input is ready again as soon as
// its result has moved into the output register.
// The output register holds a finished result while the receiver stalls; the
// next item is accepted meanwhile and waits in the controller until the
// register is free.
// Reset clears the position, target, elapsed time and direction line, loads the
// configuration defaults (200 steps, 1200 us, driver enabled) and leaves the master
// stream empty. Configuration is to be written over APB while idle; the block does not enforce it.
module stepper_angle_pointer
  import sap_pkg::*;
#(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // APB configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] angle_q6
  input  logic                   s_axis_tuser,  // [0] operation
  // Output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [0] step_pulse, [1] direction,
                                                 // [33:2] position, [34] at_target,
                                                 // [35] driver_enable_n, [39:36] zero
);

  cfg_t    cfg_q, cfg_d;
  cmd_t    cmd;
  status_t status;
  res_t    res;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_free;
  logic                   apb_write;
  logic [1:0]             reg_index;

  // Register decode: the word index is the byte address over four.
  assign reg_index = paddr[3:2];
  assign apb_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (apb_write) begin
      unique case (reg_index)
        REG_STEPS_PER_REV: cfg_d.steps_per_rev    = pwdata[CFG_W-1:0];
        REG_STEP_INTERVAL: cfg_d.step_interval_us = pwdata[CFG_W-1:0];
        REG_MOTOR_ENABLE:  cfg_d.motor_enable     = pwdata[0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_STEPS_PER_REV: prdata = APB_DATA_W'(cfg_q.steps_per_rev);
      REG_STEP_INTERVAL: prdata = APB_DATA_W'(cfg_q.step_interval_us);
      REG_MOTOR_ENABLE:  prdata = APB_DATA_W'(cfg_q.motor_enable);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steps_per_rev    <= STEPS_PER_REV_RST;
      cfg_q.step_interval_us <= STEP_INTERVAL_RST;
      cfg_q.motor_enable     <= MOTOR_ENABLE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sap_datapath #(
    .POS_WIDTH(POS_WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .cfg_i    (cfg_q),
    .angle_i  (s_axis_tdata[ANGLE_W-1:0]),
    .status_o (status),
    .res_o    (res)
  );

  // The output register can take a new result when empty or when it is being drained.
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      out_data_q <= {4'b0000, ~cfg_q.motor_enable, res.at_target, res.position,
                     res.direction, res.step_pulse};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/sap_checker.sv @@
// Port-level checker for the stepper angle pointer, bound to the top level.
// Depends on sap_pkg for port widths.
module sap_checker
  import sap_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed or dropped");

  // One item at a time: acceptance takes the block out of its idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input still ready right after an item was accepted");

  // Leaving reset, the block is idle and holds no result.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (s_axis_tready && !m_axis_tvalid))
    else $error("block not idle when leaving reset");

endmodule

bind stepper_angle_pointer sap_checker u_sap_checker (.*);
